/* sv/median_filter_2d_reflect_border_assert.svh */
// Assertion macros for the median filter block
`ifndef MEDIAN_FILTER_2D_REFLECT_BORDER_ASSERT_SVH
`define MEDIAN_FILTER_2D_REFLECT_BORDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* sv/mf2d_pkg.sv */
// Package: widths, defaults and sequencer states of the median filter
`timescale 1ns / 1ps
package mf2d_pkg;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_HALF  = 3;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PIX_W         = 8;
   localparam int FW_W          = 12;
   localparam int FH_W          = 13;
   localparam int KH_W          = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int ROW_W         = 13;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_HALF_HEIGHT  = 2'd2,
      CSR_HALF_WIDTH   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SORT,
      ST_OUT
   } state_type;

   // control from sequencer to the sorting chain
   typedef struct packed {
      logic clear;
      logic shift;
      logic use_value;
   } chain_ctrl_type;
endpackage

/* sv/mf2d_if.sv */
// Valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
interface mf2d_req_if;
   import mf2d_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             drain;
   modport source (output valid, pixel, drain, input ready);
   modport sink (input valid, pixel, drain, output ready);
endinterface

interface mf2d_rsp_if;
   import mf2d_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] median_value;
   logic             frame_end;
   modport source (output valid, median_value, frame_end, input ready);
   modport sink (input valid, median_value, frame_end, output ready);
endinterface

/* sv/mf2d_cell.sv */
// One cell of the insertion sort chain: holds one sorted sample
`timescale 1ns / 1ps
module mf2d_cell import mf2d_pkg::*; (
   input  logic             clock,
   input  chain_ctrl_type   ctrl,
   input  logic [PIX_W-1:0] new_value,
   input  logic [PIX_W-1:0] left_value,
   input  logic             left_valid,
   input  logic             left_takes,
   output logic [PIX_W-1:0] value,
   output logic             valid,
   output logic             takes
);
   logic [PIX_W-1:0] value_ff, value_in;
   logic             valid_ff, valid_in;

   // this cell takes the new sample if it is empty or holds a bigger one
   assign takes = !valid_ff || (value_ff > new_value);

   // shift right on insertion: left neighbor's entry moves in, or the new value lands here
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift && ctrl.use_value && takes) begin
         if (left_takes) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      valid_ff <= valid_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
endmodule

/* sv/mf2d_chain.sv */
// Row of sort cells: inserts samples one per cycle while shift is asserted, keeps them in order
`timescale 1ns / 1ps
module mf2d_chain import mf2d_pkg::*; #(
   parameter int NCELL = 49,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  chain_ctrl_type   ctrl,
   input  logic [PIX_W-1:0] new_value,
   input  logic [IDX_W-1:0] rank,
   output logic [PIX_W-1:0] rank_value
);
   logic [PIX_W-1:0] vals [NCELL];
   logic [NCELL-1:0] vlds;
   logic [NCELL-1:0] tks;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      if (i == 0) begin : g_first
         mf2d_cell u_cell (
            .clock(clock), .ctrl(ctrl), .new_value(new_value),
            .left_value(new_value), .left_valid(1'b0), .left_takes(1'b0),
            .value(vals[i]), .valid(vlds[i]), .takes(tks[i]));
      end else begin : g_rest
         mf2d_cell u_cell (
            .clock(clock), .ctrl(ctrl), .new_value(new_value),
            .left_value(vals[i-1]), .left_valid(vlds[i-1]), .left_takes(tks[i-1]),
            .value(vals[i]), .valid(vlds[i]), .takes(tks[i]));
      end
   end

   assign rank_value = vals[rank];
endmodule

/* sv/median_filter_2d_reflect_border.sv */
// Top level: line store, raster counters, window sequencer and sort chain
//  channel  | dir | handshake     | payload
//  req      | in  | valid/ready   | pixel, drain
//  rsp      | out | valid/ready   | median_value, frame_end
//  csr      | in  | write enable  | csr_index, csr_data
// A request that emits no result is only accepted; one that emits a result
// goes through the accept, one line store
// read per window sample (each inserted into the sort chain in the cycle after its read), the
// insertion of the last sample, and the load of the output register.
// Synchronous active-high reset clears counters, state and settings to defaults.
// A stalled result holds in the output register; no request is taken meanwhile.
`timescale 1ns / 1ps
`include "median_filter_2d_reflect_border_assert.svh"
module median_filter_2d_reflect_border import mf2d_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HALF  = DEF_MAX_HALF
) (
   input  logic                  clock,
   input  logic                  reset,
   mf2d_req_if.sink              req,
   mf2d_rsp_if.source            rsp,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int RING_W = $clog2(2 * MAX_HALF + 2);
   localparam int RING  = 2 ** RING_W;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int MW_W  = COL_W + 1;
   localparam int KSIDE = 2 * MAX_HALF + 1;
   localparam int NCELL = KSIDE * KSIDE;
   localparam int IDX_W = $clog2(NCELL);
   localparam int HF_W  = $clog2(MAX_HALF + 1);
   localparam int D_W   = HF_W + 1;
   localparam int LIN_W = MW_W + ROW_W + 1;

   // configuration registers
   logic [FW_W-1:0] cfg_w_ff;
   logic [FH_W-1:0] cfg_h_ff;
   logic [KH_W-1:0] cfg_hh_ff, cfg_hw_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= FW_W'(2048);
         cfg_h_ff <= FH_W'(512);
         cfg_hh_ff <= KH_W'(1);
         cfg_hw_ff <= KH_W'(1);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  cfg_w_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: cfg_h_ff  <= csr_data[FH_W-1:0];
            CSR_HALF_HEIGHT:  cfg_hh_ff <= csr_data[KH_W-1:0];
            CSR_HALF_WIDTH:   cfg_hw_ff <= csr_data[KH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped values of the registers
   logic [MW_W-1:0]  cw;
   logic [ROW_W-1:0] ch;
   logic [HF_W-1:0]  chh, chw;
   always_comb begin
      cw = (cfg_w_ff == '0) ? MW_W'(1) :
           (32'(cfg_w_ff) > MAX_WIDTH) ? MW_W'(MAX_WIDTH) : MW_W'(cfg_w_ff);
      ch = (cfg_h_ff == '0) ? ROW_W'(1) :
           (cfg_h_ff > 13'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : cfg_h_ff;
      chh = (32'(cfg_hh_ff) > MAX_HALF) ? HF_W'(MAX_HALF) : HF_W'(cfg_hh_ff);
      chw = (32'(cfg_hw_ff) > MAX_HALF) ? HF_W'(MAX_HALF) : HF_W'(cfg_hw_ff);
      if (32'(chh) > 32'(ch) - 1) chh = HF_W'(ch - 1'b1);
      if (32'(chw) > 32'(cw) - 1) chw = HF_W'(cw - 1'b1);
   end

   // active (latched) frame settings and counters
   logic [MW_W-1:0]  aw_ff, aw_in;
   logic [ROW_W-1:0] ah_ff, ah_in;
   logic [HF_W-1:0]  ahh_ff, ahh_in, ahw_ff, ahw_in;
   logic [ROW_W-1:0] irow_ff, irow_in, orow_ff, orow_in;
   logic [MW_W-1:0]  icol_ff, icol_in, ocol_ff, ocol_in;
   logic             idone_ff, idone_in;
   state_type        state_ff, state_in;

   // window walk
   logic signed [D_W-1:0] dy_ff, dy_in, dx_ff, dx_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  fend_ff, fend_in;
   logic [PIX_W-1:0]      med_ff, med_in;

   // line store
   logic [PIX_W-1:0] mem [RING * MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic [RING_W+COL_W-1:0] wr_addr, rd_addr;
   logic             wr_en, rd_en;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req.pixel;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // reflect-101 of a position plus offset
   function automatic logic [ROW_W-1:0] reflect(input logic [ROW_W-1:0] pos,
                                                input logic signed [D_W-1:0] d,
                                                input logic [ROW_W-1:0] n);
      logic signed [ROW_W+1:0] x;
      x = $signed({2'b00, pos}) + (ROW_W+2)'(d);
      if (x < 0) x = -x;
      if (x > $signed({2'b00, n}) - 1) x = $signed({1'b0, n, 1'b0}) - 2 - x;
      return x[ROW_W-1:0];
   endfunction

   logic [ROW_W-1:0] ry, rx;
   assign ry = reflect(orow_ff, dy_ff, ah_ff);
   assign rx = reflect(ROW_W'(ocol_ff), dx_ff, ROW_W'(aw_ff));
   assign rd_addr = {ry[RING_W-1:0], rx[COL_W-1:0]};
   assign wr_addr = {irow_ff[RING_W-1:0], icol_ff[COL_W-1:0]};

   // readiness: linear index compare
   logic [LIN_W-1:0] in_lin, need;
   logic [ROW_W-1:0] nrow;
   logic [MW_W-1:0]  ncol;
   logic             store, emit;
   logic [LIN_W-1:0] ai_lin;
   logic [ROW_W-1:0] ilrow;
   logic [MW_W-1:0]  ilcol;
   logic             ildone;

   chain_ctrl_type   cc;
   logic [PIX_W-1:0] rank_value;
   logic [IDX_W-1:0] rank;
   logic             accept, first;
   logic             rsp_vld_ff;

   assign accept = req.valid && req.ready;
   assign first = (irow_ff == '0) && (icol_ff == '0) && (orow_ff == '0) && (ocol_ff == '0)
                  && !idone_ff;
   assign rank = IDX_W'(((2 * ahh_ff + 1) * (2 * ahw_ff + 1) - 1) / 2);

   always_comb begin
      state_in = state_ff;
      aw_in = aw_ff; ah_in = ah_ff; ahh_in = ahh_ff; ahw_in = ahw_ff;
      irow_in = irow_ff; icol_in = icol_ff; idone_in = idone_ff;
      orow_in = orow_ff; ocol_in = ocol_ff;
      dy_in = dy_ff; dx_in = dx_ff; cnt_in = cnt_ff;
      rd_vld_in = 1'b0; fend_in = fend_ff; med_in = med_ff;
      wr_en = 1'b0; rd_en = 1'b0;
      cc = '0;
      req.ready = 1'b0;
      ilrow = irow_ff; ilcol = icol_ff; ildone = idone_ff;
      store = 1'b0; emit = 1'b0;
      in_lin = '0; need = '0; nrow = '0; ncol = '0; ai_lin = '0;
      case (state_ff)
         ST_IDLE: begin
            // hold off requests while a result waits in the output register
            req.ready = !rsp_vld_ff || rsp.ready;
            if (accept) begin
               if (first) begin
                  aw_in = cw; ah_in = ch; ahh_in = chh; ahw_in = chw;
               end
               store = !req.drain && !idone_ff;
               if (store) begin
                  wr_en = 1'b1;
                  if (icol_ff + 1'b1 >= aw_in) begin
                     ilcol = '0;
                     if (irow_ff + 1'b1 >= ah_in) ildone = 1'b1;
                     else ilrow = irow_ff + 1'b1;
                  end else begin
                     ilcol = icol_ff + 1'b1;
                  end
               end
               irow_in = ilrow; icol_in = ilcol; idone_in = ildone;
               in_lin = ildone ? LIN_W'(ah_in) * LIN_W'(aw_in)
                               : LIN_W'(ilrow) * LIN_W'(aw_in) + LIN_W'(ilcol);
               nrow = orow_ff + ROW_W'(ahh_in);
               if (nrow > ah_in - 1'b1) nrow = ah_in - 1'b1;
               ncol = ocol_ff + MW_W'(ahw_in);
               if (ncol > aw_in - 1'b1) ncol = aw_in - 1'b1;
               need = LIN_W'(nrow) * LIN_W'(aw_in) + LIN_W'(ncol);
               ai_lin = in_lin;
               emit = ai_lin > need;
               if (emit) begin
                  cc.clear = 1'b1;
                  dy_in = -D_W'(ahh_in);
                  dx_in = -D_W'(ahw_in);
                  cnt_in = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // read one window sample a cycle, insert the one read before
            rd_en = 1'b1;
            rd_vld_in = 1'b1;
            cc.shift = rd_vld_ff; cc.use_value = rd_vld_ff;
            if (dx_ff == D_W'(ahw_ff)) begin
               dx_in = -D_W'(ahw_ff);
               if (dy_ff == D_W'(ahh_ff)) state_in = ST_SORT;
               else dy_in = dy_ff + 1'b1;
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         ST_SORT: begin
            // insert the last sample
            cc.shift = 1'b1; cc.use_value = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
            med_in = rank_value;
            fend_in = 1'b0;
            if (ocol_ff + 1'b1 >= aw_ff) begin
               ocol_in = '0;
               if (orow_ff + 1'b1 >= ah_ff) begin
                  fend_in = 1'b1;
                  orow_in = '0; irow_in = '0; icol_in = '0; idone_in = 1'b0;
               end else begin
                  orow_in = orow_ff + 1'b1;
               end
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   mf2d_chain #(.NCELL(NCELL), .IDX_W(IDX_W)) u_chain (
      .clock(clock), .ctrl(cc), .new_value(rd_data_ff), .rank(rank),
      .rank_value(rank_value));

   // output register: loaded in ST_OUT, which is entered only when empty
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         irow_ff <= '0; icol_ff <= '0; orow_ff <= '0; ocol_ff <= '0;
         idone_ff <= 1'b0; rd_vld_ff <= 1'b0; rsp_vld_ff <= 1'b0;
         aw_ff <= MW_W'(1); ah_ff <= ROW_W'(1); ahh_ff <= '0; ahw_ff <= '0;
      end else begin
         state_ff <= (state_ff == ST_IDLE && rsp_vld_ff && !rsp.ready) ? ST_IDLE : state_in;
         if (!(state_ff == ST_IDLE && rsp_vld_ff && !rsp.ready)) begin
            irow_ff <= irow_in; icol_ff <= icol_in; idone_ff <= idone_in;
            orow_ff <= orow_in; ocol_ff <= ocol_in;
            aw_ff <= aw_in; ah_ff <= ah_in; ahh_ff <= ahh_in; ahw_ff <= ahw_in;
         end
         rd_vld_ff <= rd_vld_in;
         if (state_ff == ST_OUT) rsp_vld_ff <= 1'b1;
         else if (rsp.ready) rsp_vld_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      dy_ff <= dy_in; dx_ff <= dx_in; cnt_ff <= cnt_in;
      med_ff <= med_in; fend_ff <= fend_in;
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.median_value = med_ff;
   assign rsp.frame_end = fend_ff;

   `ASSERT_IMPLIES(a_no_req_busy, clock, reset, state_ff != ST_IDLE, !req.ready)
   `ASSERT_NEXT(a_out_valid, clock, reset, state_ff == ST_OUT, rsp.valid)
   `ASSERT_IMPLIES(a_fend_resets, clock, reset,
                   rsp.valid && rsp.frame_end && state_ff == ST_IDLE,
                   orow_ff == '0 && ocol_ff == '0)
endmodule
